### rtl/sensor_reply_frame_receiver_core_defines.svh
// Assertion macros used by the checker file of the reply frame receiver.
`ifndef SENSOR_REPLY_FRAME_RECEIVER_CORE_DEFINES_SVH
`define SENSOR_REPLY_FRAME_RECEIVER_CORE_DEFINES_SVH

// Property checked at every rising clock edge while reset is released.
`define SRFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every rising clock edge, reset cycles included.
`define SRFR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/srfr_pkg.sv
package srfr_pkg;

  localparam int unsigned PAYLOAD_BYTES_DEF = 6;
  localparam int unsigned REPORTED_BYTES    = 6;

  localparam logic [7:0] START_CODE = 8'hFF;
  localparam logic [7:0] CMD_RESET  = 8'h86;

  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;

  // Word index of each register: byte address bit 2.
  localparam logic REG_EXPECTED_CMD = 1'b0;

  typedef enum logic [1:0] {
    PH_START,
    PH_CMD,
    PH_DATA,
    PH_CHECK
  } phase_t;

endpackage

### rtl/srfr_cfg_regs.sv
module srfr_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [srfr_pkg::ADDR_W-1:0] paddr,
  input  logic [srfr_pkg::DATA_W-1:0] pwdata,
  output logic [srfr_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output logic [7:0]                  expected_cmd
);
  import srfr_pkg::*;

  logic [7:0] expected_cmd_r;
  logic       wr_en;
  logic       word_idx;

  assign word_idx = paddr[2];
  assign pready   = 1'b1;
  assign wr_en    = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_cmd_r <= CMD_RESET;
    end else if (wr_en && (word_idx == REG_EXPECTED_CMD)) begin
      expected_cmd_r <= pwdata[7:0];
    end
  end

  always_comb begin
    unique case (word_idx)
      REG_EXPECTED_CMD: prdata = {{(DATA_W-8){1'b0}}, expected_cmd_r};
      default:          prdata = '0;
    endcase
  end

  assign expected_cmd = expected_cmd_r;

endmodule

### rtl/sensor_reply_frame_receiver_core.sv
// Reply frame receiver: takes one received serial byte per transfer on the in_ channel and
// picks out frames of the form 0xFF, command, PAYLOAD_BYTES data bytes, checksum. After a
// start byte the next byte must match the expected_cmd register (byte address 0, reset 0x86);
// a mismatching byte is examined again as a start byte. On the checksum byte one transfer
// leaves on the out_ channel with the first six data bytes (zero where the payload is
// shorter) and out_frame_ok, which is set when the 8-bit sum of every byte after the start
// byte, checksum included, is zero. No other byte produces a result. A byte is taken in
// every clock cycle unless the input stalls: the frame state updates in the cycle of the
// transfer and the result appears on the registered output in the cycle after. The input
// stalls only when the next byte is a checksum and the output register still holds a result
// that its receiver stalls. Configuration is written through the APB port and should change
// only while no frame is in progress.
module sensor_reply_frame_receiver_core #(
  parameter int unsigned PAYLOAD_BYTES = srfr_pkg::PAYLOAD_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // Byte input channel.
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  in_rx_byte,
  // Result channel.
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_frame_ok,
  output logic [7:0]                  out_data_byte0,
  output logic [7:0]                  out_data_byte1,
  output logic [7:0]                  out_data_byte2,
  output logic [7:0]                  out_data_byte3,
  output logic [7:0]                  out_data_byte4,
  output logic [7:0]                  out_data_byte5,
  // Configuration port.
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [srfr_pkg::ADDR_W-1:0] paddr,
  input  logic [srfr_pkg::DATA_W-1:0] pwdata,
  output logic [srfr_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import srfr_pkg::*;

  localparam int unsigned IDX_W = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PAYLOAD_BYTES - 1);

  logic [7:0] expected_cmd;

  srfr_cfg_regs u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .expected_cmd (expected_cmd)
  );

  // Frame tracking state.
  phase_t           phase_r, phase_nxt;
  logic [7:0]       sum_r, sum_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [7:0]       store_r [PAYLOAD_BYTES];

  // Result register.
  logic       out_valid_r;
  logic       out_ok_r;
  logic [7:0] out_data_r [REPORTED_BYTES];

  logic       accept;
  logic       store_wr;
  logic       emit;
  logic [7:0] sum_add;
  logic [7:0] report [REPORTED_BYTES];

  // Only a checksum byte needs the output register, so only then can the input stall.
  assign in_stall = (phase_r == PH_CHECK) && out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign sum_add  = sum_r + in_rx_byte;

  always_comb begin
    phase_nxt = phase_r;
    sum_nxt   = sum_r;
    idx_nxt   = idx_r;
    store_wr  = 1'b0;
    emit      = 1'b0;
    unique case (phase_r)
      PH_START: begin
        if (in_rx_byte == START_CODE) begin
          sum_nxt   = '0;
          phase_nxt = PH_CMD;
        end
      end
      PH_CMD: begin
        if (in_rx_byte == expected_cmd) begin
          sum_nxt   = sum_add;
          idx_nxt   = '0;
          phase_nxt = PH_DATA;
        end else if (in_rx_byte == START_CODE) begin
          // The rejected command byte opens a new frame right away.
          sum_nxt   = '0;
          phase_nxt = PH_CMD;
        end else begin
          phase_nxt = PH_START;
        end
      end
      PH_DATA: begin
        sum_nxt  = sum_add;
        store_wr = 1'b1;
        idx_nxt  = idx_r + 1'b1;
        if (idx_r == LAST_IDX) begin
          phase_nxt = PH_CHECK;
        end
      end
      PH_CHECK: begin
        sum_nxt   = sum_add;
        emit      = 1'b1;
        phase_nxt = PH_START;
      end
      default: begin
        phase_nxt = PH_START;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      sum_r   <= '0;
      idx_r   <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      sum_r   <= sum_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // Payload store: one byte register per payload position.
  for (genvar k = 0; k < PAYLOAD_BYTES; k++) begin : g_store
    always_ff @(posedge clk) begin
      if (accept && store_wr && (idx_r == IDX_W'(k))) begin
        store_r[k] <= in_rx_byte;
      end
    end
  end

  // Reported bytes: positions beyond a short payload read as zero.
  for (genvar j = 0; j < REPORTED_BYTES; j++) begin : g_report
    if (j < PAYLOAD_BYTES) begin : g_have
      assign report[j] = store_r[j];
    end else begin : g_none
      assign report[j] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept && emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      out_ok_r   <= (sum_add == 8'd0);
      out_data_r <= report;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_frame_ok   = out_ok_r;
  assign out_data_byte0 = out_data_r[0];
  assign out_data_byte1 = out_data_r[1];
  assign out_data_byte2 = out_data_r[2];
  assign out_data_byte3 = out_data_r[3];
  assign out_data_byte4 = out_data_r[4];
  assign out_data_byte5 = out_data_r[5];

endmodule

### rtl/srfr_checker.sv
`include "sensor_reply_frame_receiver_core_defines.svh"

module srfr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_frame_ok,
  input logic [7:0] out_data_byte0,
  input logic [7:0] out_data_byte5,
  input logic       pready
);

  `SRFR_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "result dropped while stalled")
  `SRFR_ASSERT(a_out_stable, out_valid && out_stall |=> $stable(out_frame_ok) && $stable(out_data_byte0) && $stable(out_data_byte5), "stalled result changed")
  `SRFR_ASSERT(a_stall_cause, in_stall |-> out_valid && out_stall, "input stalled with no waiting result")
  `SRFR_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid, "result valid right after reset")
  `SRFR_ASSERT_ALWAYS(a_pready, pready, "pready low")

endmodule

bind sensor_reply_frame_receiver_core srfr_checker u_srfr_checker (.*);
